### src/tvgh_pkg.sv
package tvgh_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MUL_W       = 34;

    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_ONE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATIO_TWO = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAN_ONE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAN_TWO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WET       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO    = 3'd6;

    localparam logic [29:0] PI_Q28      = 30'd843314857;
    localparam logic [32:0] RECIP_FIVE  = 33'h0CCCCCCCD;
    localparam logic [32:0] RECIP_THREE = 33'h0AAAAAAAB;
    localparam logic [28:0] ONE_Q28     = 29'h1000_0000;
    localparam logic [15:0] WET_GAIN    = 16'd21299;
    localparam logic [15:0] WET_MIN     = 16'd3;
    localparam logic [15:0] UNITY_Q15   = 16'd32768;
    localparam logic [14:0] UNITY_Q14   = 15'd16384;
    localparam logic signed [47:0] ROUND_Q29 = 48'sd268435456;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } result_t;

    typedef struct packed {
        logic        [15:0] ratio_voice_one;
        logic        [15:0] ratio_voice_two;
        logic signed [15:0] pan_voice_one;
        logic signed [15:0] pan_voice_two;
        logic        [15:0] wet_level;
        logic               bypass_enable;
        logic               stereo_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [5:0] {
        STEP_W0, STEP_W1, STEP_W2, STEP_W3, STEP_W4, STEP_W5, STEP_W6,
        STEP_W7, STEP_W8, STEP_W9, STEP_W10, STEP_W11, STEP_W12, STEP_W13,
        STEP_V0, STEP_V1, STEP_V2, STEP_V3, STEP_V4, STEP_V5, STEP_V6, STEP_V7,
        STEP_X0, STEP_X1, STEP_X2, STEP_X3, STEP_X4, STEP_X5, STEP_X6,
        STEP_X7, STEP_X8, STEP_X9, STEP_X10, STEP_X11, STEP_X12, STEP_X13
    } step_t;

    typedef struct packed {
        logic       capture;
        logic       run;
        step_t      step;
        logic [1:0] lane;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_q29(input logic signed [47:0] x);
        logic signed [18:0] y;
        y = 19'(x >>> 29);
        if (y > 19'sd32767)
            return 16'sh7FFF;
        else if (y < -19'sd32768)
            return 16'sh8000;
        return y[15:0];
    endfunction

endpackage

### src/tvgh_cfg.sv
module tvgh_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [tvgh_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [tvgh_pkg::CFG_DATA_W-1:0]  wr_data,
    output tvgh_pkg::cfg_t                 cfg
);
    import tvgh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_RATIO_ONE: cfg_next.ratio_voice_one = wr_data;
                REG_RATIO_TWO: cfg_next.ratio_voice_two = wr_data;
                REG_PAN_ONE:   cfg_next.pan_voice_one   = $signed(wr_data);
                REG_PAN_TWO:   cfg_next.pan_voice_two   = $signed(wr_data);
                REG_WET:       cfg_next.wet_level       = wr_data;
                REG_BYPASS:    cfg_next.bypass_enable   = wr_data[0];
                REG_STEREO:    cfg_next.stereo_mode     = wr_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_voice_one <= 16'd16384;
            cfg_reg.ratio_voice_two <= 16'd16384;
            cfg_reg.pan_voice_one   <= '0;
            cfg_reg.pan_voice_two   <= '0;
            cfg_reg.wet_level       <= '0;
            cfg_reg.bypass_enable   <= 1'b0;
            cfg_reg.stereo_mode     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/tvgh_ctrl.sv
module tvgh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  tvgh_pkg::dp_status_t status,
    output tvgh_pkg::dp_cmd_t    cmd
);
    import tvgh_pkg::*;

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic [1:0]  lane_reg, lane_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        lane_next  = lane_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_W0;
                lane_next = 2'd0;
                if (sample_valid)
                    state_next = status.active ? ST_RUN : ST_DONE;
            end
            ST_RUN:
            begin
                if (step_reg == STEP_X13)
                    state_next = ST_DONE;
                else if (step_reg == STEP_V7 && lane_reg != 2'd3)
                begin
                    step_next = STEP_V0;
                    lane_next = lane_reg + 2'd1;
                end
                else
                    step_next = step_t'(step_reg + 6'd1);
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall = (state_reg != ST_IDLE);
        cmd.capture  = (state_reg == ST_IDLE) && sample_valid;
        cmd.run      = (state_reg == ST_RUN);
        cmd.step     = step_reg;
        cmd.lane     = lane_reg;
        cmd.finish   = (state_reg == ST_DONE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_W0;
            lane_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            lane_reg  <= lane_next;
        end
    end

endmodule

### src/tvgh_dp.sv
module tvgh_dp #(
    parameter int GRAIN_LENGTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvgh_pkg::cfg_t       cfg,
    input  tvgh_pkg::dp_cmd_t    cmd,
    output tvgh_pkg::dp_status_t status,
    input  tvgh_pkg::sample_t    sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tvgh_pkg::result_t    result
);
    import tvgh_pkg::*;

    localparam int GL_BITS = $clog2(GRAIN_LENGTH);
    localparam int ADDR_W  = GL_BITS + 1;
    localparam int DEPTH   = 2 * GRAIN_LENGTH;
    localparam int QW      = ADDR_W + 14;
    localparam int PW      = 2 * MUL_W;
    localparam logic [GL_BITS:0] GL_FULL    = (GL_BITS+1)'(GRAIN_LENGTH);
    localparam logic [GL_BITS:0] GL_HALF    = (GL_BITS+1)'(GRAIN_LENGTH / 2);
    localparam logic [GL_BITS:0] GL_QUARTER = (GL_BITS+1)'(GRAIN_LENGTH / 4);
    localparam logic [ADDR_W:0]  FILL_FULL  = (ADDR_W+1)'(DEPTH);

    logic signed [15:0] store_one [DEPTH];
    logic signed [15:0] store_two [DEPTH];

    logic signed [15:0] in_l_reg, in_r_reg, mono_reg;
    logic               active_reg;
    logic [ADDR_W-1:0]  wpos_reg;
    logic [GL_BITS-1:0] gphase_reg;
    logic [ADDR_W:0]    fill_reg;
    logic signed [PW-1:0] prod_reg;
    logic [27:0]        a_reg, a2_reg, x_reg, s_reg;
    logic [28:0]        t_reg;
    logic [15:0]        w0_reg;
    logic [QW-1:0]      rq_reg;
    logic signed [15:0] rd_one0_reg, rd_one1_reg, rd_two0_reg, rd_two1_reg;
    logic [1:0]         vld_reg;
    logic signed [30:0] smp_reg;
    logic signed [47:0] acc_reg;
    logic signed [17:0] v1_reg, v2_reg;
    logic [16:0]        dry_reg;
    logic signed [47:0] macc_reg;
    logic signed [33:0] vs_reg;
    logic signed [15:0] out_l_reg, out_r_reg;
    result_t            result_reg;
    logic               result_valid_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic               active_w;
    logic [15:0]        wet_c;
    logic signed [16:0] p1, p2;
    logic [14:0]        g1l, g1r, g2l, g2r;
    logic [GL_BITS:0]   gp_w, u_w, v_w;
    logic               flip_w;
    logic [GL_BITS-1:0] gp_lane;
    logic [GL_BITS:0]   delay_w;
    logic [15:0]        ratio_w, w_lane, ssq_w;
    logic [ADDR_W-1:0]  addr0, addr1;
    logic               vld0_w, vld1_w;
    logic signed [15:0] s0_w, s1_w;
    logic [13:0]        frac_w;
    logic signed [16:0] lr_sum;
    logic signed [47:0] vsum_w, osum_w;
    logic [30:0]        dsum_w;
    logic               mem_we;

    function automatic logic signed [16:0] clamp_pan(input logic signed [15:0] p);
        if (p > 16'sd16384)
            return 17'sd16384;
        else if (p < -16'sd16384)
            return -17'sd16384;
        return 17'(p);
    endfunction

    always_comb
    begin
        active_w = !cfg.bypass_enable && (cfg.wet_level > WET_MIN);
        wet_c    = (cfg.wet_level > UNITY_Q15) ? UNITY_Q15 : cfg.wet_level;
        p1  = clamp_pan(cfg.pan_voice_one);
        p2  = clamp_pan(cfg.pan_voice_two);
        g1l = (p1 <= 0) ? UNITY_Q14 : 15'(17'sd16384 - p1);
        g1r = (p1 >= 0) ? UNITY_Q14 : 15'(17'sd16384 + p1);
        g2l = (p2 <= 0) ? UNITY_Q14 : 15'(17'sd16384 - p2);
        g2r = (p2 >= 0) ? UNITY_Q14 : 15'(17'sd16384 + p2);
        lr_sum = 17'(sample.left_in) + 17'(sample.right_in);

        gp_w   = (GL_BITS+1)'(gphase_reg);
        u_w    = (gp_w > GL_HALF) ? GL_FULL - gp_w : gp_w;
        flip_w = (u_w > GL_QUARTER);
        v_w    = flip_w ? GL_HALF - u_w : u_w;
        ssq_w  = prod_reg[41 +: 16];

        gp_lane = gphase_reg + (cmd.lane[0] ? GL_HALF[GL_BITS-1:0] : '0);
        delay_w = GL_FULL - (GL_BITS+1)'(gp_lane);
        ratio_w = cmd.lane[1] ? cfg.ratio_voice_two : cfg.ratio_voice_one;
        w_lane  = cmd.lane[0] ? UNITY_Q15 - w0_reg : w0_reg;

        addr0  = rq_reg[QW-1:14];
        addr1  = addr0 + 1'b1;
        frac_w = rq_reg[13:0];
        vld0_w = ((ADDR_W+1)'(addr0) < fill_reg) || (addr0 == wpos_reg);
        vld1_w = ((ADDR_W+1)'(addr1) < fill_reg) || (addr1 == wpos_reg);
        s0_w = !vld_reg[0] ? '0 : (cmd.lane[1] ? rd_two0_reg : rd_one0_reg);
        s1_w = !vld_reg[1] ? '0 : (cmd.lane[1] ? rd_two1_reg : rd_one1_reg);

        vsum_w = acc_reg + $signed(prod_reg[47:0]) + ROUND_Q29;
        osum_w = macc_reg + $signed(prod_reg[47:0]) + ROUND_Q29;
        dsum_w = prod_reg[30:0] + 31'd16384;
        mem_we = cmd.run && (cmd.step == STEP_W0);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_W0:  begin mul_a = MUL_W'(v_w);         mul_b = MUL_W'(PI_Q28);      end
            STEP_W2:  begin mul_a = MUL_W'(a_reg);       mul_b = MUL_W'(a_reg);       end
            STEP_W4:  begin mul_a = MUL_W'(a2_reg >> 2); mul_b = MUL_W'(RECIP_FIVE);  end
            STEP_W6:  begin mul_a = MUL_W'(a2_reg);      mul_b = MUL_W'(t_reg);       end
            STEP_W8:  begin mul_a = MUL_W'(x_reg >> 1);  mul_b = MUL_W'(RECIP_THREE); end
            STEP_W10: begin mul_a = MUL_W'(a_reg);       mul_b = MUL_W'(t_reg);       end
            STEP_W12: begin mul_a = MUL_W'(s_reg);       mul_b = MUL_W'(s_reg);       end
            STEP_V0:  begin mul_a = MUL_W'(delay_w);     mul_b = MUL_W'(ratio_w);     end
            STEP_V3:
            begin
                mul_a = MUL_W'(s0_w);
                mul_b = MUL_W'(15'(UNITY_Q14 - 15'(frac_w)));
            end
            STEP_V4:  begin mul_a = MUL_W'(s1_w);        mul_b = MUL_W'(frac_w);      end
            STEP_V6:  begin mul_a = MUL_W'(smp_reg);     mul_b = MUL_W'(w_lane);      end
            STEP_X0:  begin mul_a = MUL_W'(wet_c);       mul_b = MUL_W'(WET_GAIN);    end
            STEP_X2:  begin mul_a = MUL_W'(in_l_reg);    mul_b = MUL_W'(dry_reg);     end
            STEP_X3:  begin mul_a = MUL_W'(v1_reg);      mul_b = MUL_W'(g1l);         end
            STEP_X4:  begin mul_a = MUL_W'(v2_reg);      mul_b = MUL_W'(g2l);         end
            STEP_X6:  begin mul_a = MUL_W'(vs_reg);      mul_b = MUL_W'(wet_c);       end
            STEP_X8:  begin mul_a = MUL_W'(in_r_reg);    mul_b = MUL_W'(dry_reg);     end
            STEP_X9:  begin mul_a = MUL_W'(v1_reg);      mul_b = MUL_W'(g1r);         end
            STEP_X10: begin mul_a = MUL_W'(v2_reg);      mul_b = MUL_W'(g2r);         end
            STEP_X12: begin mul_a = MUL_W'(vs_reg);      mul_b = MUL_W'(wet_c);       end
            default:  begin mul_a = '0;                  mul_b = '0;                  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_one[wpos_reg] <= mono_reg;
            store_two[wpos_reg] <= mono_reg;
        end
        rd_one0_reg <= store_one[addr0];
        rd_one1_reg <= store_one[addr1];
        rd_two0_reg <= store_two[addr0];
        rd_two1_reg <= store_two[addr1];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            in_l_reg   <= sample.left_in;
            in_r_reg   <= sample.right_in;
            mono_reg   <= cfg.stereo_mode ? lr_sum[16:1] : sample.left_in;
            active_reg <= active_w;
        end
        if (cmd.run)
        begin
            case (cmd.step)
                STEP_W1:  a_reg  <= prod_reg[GL_BITS +: 28];
                STEP_W3:  a2_reg <= prod_reg[28 +: 28];
                STEP_W5:  t_reg  <= ONE_Q28 - 29'(prod_reg[34 +: 24]);
                STEP_W7:  x_reg  <= prod_reg[28 +: 28];
                STEP_W9:  t_reg  <= ONE_Q28 - 29'(prod_reg[33 +: 26]);
                STEP_W11: s_reg  <= prod_reg[28 +: 28];
                STEP_W13: w0_reg <= flip_w ? UNITY_Q15 - ssq_w : ssq_w;
                STEP_V1:  rq_reg <= {wpos_reg, 14'd0} - prod_reg[QW-1:0];
                STEP_V2:  vld_reg <= {vld1_w, vld0_w};
                STEP_V4:  smp_reg <= $signed(prod_reg[30:0]);
                STEP_V5:  smp_reg <= smp_reg + $signed(prod_reg[30:0]);
                STEP_V7:
                begin
                    if (!cmd.lane[0])
                        acc_reg <= $signed(prod_reg[47:0]);
                    else if (cmd.lane[1])
                        v2_reg <= 18'(vsum_w >>> 29);
                    else
                        v1_reg <= 18'(vsum_w >>> 29);
                end
                STEP_X1:  dry_reg <= 17'(17'd32768 - 17'(dsum_w[30:15]));
                STEP_X3,
                STEP_X9:  macc_reg <= 48'($signed(prod_reg[33:0])) <<< 14;
                STEP_X4,
                STEP_X10: vs_reg <= $signed(prod_reg[33:0]);
                STEP_X5,
                STEP_X11: vs_reg <= vs_reg + $signed(prod_reg[33:0]);
                STEP_X7:  out_l_reg <= sat_q29(osum_w);
                STEP_X13: out_r_reg <= sat_q29(osum_w);
                default:  vld_reg <= vld_reg;
            endcase
        end
        if (cmd.finish)
        begin
            if (active_reg)
            begin
                result_reg.left_out  <= out_l_reg;
                result_reg.right_out <= cfg.stereo_mode ? out_r_reg : in_r_reg;
            end
            else
            begin
                result_reg.left_out  <= in_l_reg;
                result_reg.right_out <= in_r_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg         <= '0;
            gphase_reg       <= '0;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish && active_reg)
            begin
                wpos_reg   <= wpos_reg + 1'b1;
                gphase_reg <= gphase_reg + 1'b1;
                if (fill_reg != FILL_FULL)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.finish)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign status.active   = active_w;
    assign status.out_free = !result_valid_reg || !result_stall;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

endmodule

### src/two_voice_granular_harmonizer.sv
// Processing: each input sample runs through sixty sequenced steps on one shared multiplier
// (four grain reads); in bypass the step sequence is skipped. A new sample is taken only
// once the previous result has been loaded into the output register, so items never overlap.
// Reset: registers take their defaults, delay stores read as zero through a fill count
// (no clearing pass), write position and grain phase return to zero.
module two_voice_granular_harmonizer #(
    parameter int GRAIN_LENGTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  tvgh_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output tvgh_pkg::result_t                result,
    input  logic                             wr_en,
    input  logic [tvgh_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [tvgh_pkg::CFG_DATA_W-1:0]  wr_data
);
    import tvgh_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    tvgh_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    tvgh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    tvgh_dp #(
        .GRAIN_LENGTH (GRAIN_LENGTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
